/* hdl/cwpa_pkg.sv */
// Shared types, constants and small lookup functions for the packed weight address generator.
// The configuration, pipeline stage and top-level files refer to this package by scoped names.
package cwpa_pkg;

	localparam int MaxChannels = 4096;
	localparam int MaxKernels  = 4096;
	localparam int HeadBytes   = 512;
	localparam int BiasBytes   = 16;

	localparam logic [1:0] FUNC_WEIGHT = 2'd0;
	localparam logic [1:0] FUNC_BIAS   = 2'd1;
	localparam logic [1:0] FUNC_PRELU  = 2'd2;
	localparam logic [1:0] FUNC_SIZE   = 2'd3;

	localparam logic [2:0] REG_KW    = 3'd0;
	localparam logic [2:0] REG_KH    = 3'd1;
	localparam logic [2:0] REG_CC    = 3'd2;
	localparam logic [2:0] REG_KC    = 3'd3;
	localparam logic [2:0] REG_QUANT = 3'd4;
	localparam logic [2:0] REG_PRELU = 3'd5;

	typedef struct packed {
		logic [2:0]  kw;
		logic [2:0]  kh;
		logic [12:0] cc;
		logic [12:0] kc;
		logic        quant;
		logic        prelu;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [11:0] kernel_index;
		logic [11:0] channel_index;
		logic [2:0]  tap_row;
		logic [2:0]  tap_col;
		logic [15:0] element_value;
	} req_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        err;
		logic        quant;
		logic        prelu;
		logic [9:0]  gsel;
		logic [22:0] grp_full;
		logic [6:0]  mct;
		logic [8:0]  cci;
		logic [2:0]  mk;
		logic [3:0]  tiles_m;
		logic [2:0]  xoff;
		logic [3:0]  last;
		logic [12:0] nt;
		logic [6:0]  slot;
		logic [15:0] value;
	} s1_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        err;
		logic        quant;
		logic        prelu;
		logic [31:0] gmul;
		logic [16:0] tindex;
		logic [6:0]  slot;
		logic [2:0]  mk;
		logic [15:0] value;
	} s2_t;

	typedef struct packed {
		logic [1:0]  func;
		logic        err;
		logic [32:0] suma;
		logic [25:0] sumb;
		logic [1:0]  ebytes;
		logic [15:0] value;
	} s3_t;

	// Slot of the seventh column of a 7x7 kernel, which is folded into spare tile slots.
	function automatic logic [6:0] col_seven(input logic [2:0] idx);
		logic [6:0] r;
		unique case (idx)
			3'd0: r = 7'd17;
			3'd1: r = 7'd3;
			3'd2: r = 7'd9;
			3'd3: r = 7'd15;
			3'd4: r = 7'd0;
			3'd5: r = 7'd6;
			3'd6: r = 7'd12;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] div3(input logic [2:0] v);
		logic [1:0] r;
		unique case (v)
			3'd0, 3'd1, 3'd2: r = 2'd0;
			3'd3, 3'd4, 3'd5: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] mod3(input logic [2:0] v);
		logic [1:0] r;
		unique case (v)
			3'd0, 3'd3, 3'd6: r = 2'd0;
			3'd1, 3'd4, 3'd7: r = 2'd1;
			default: r = 2'd2;
		endcase
		return r;
	endfunction

endpackage

/* hdl/cwpa_if.sv */
// Request and response channel interfaces of the packed weight address generator.
// Standalone; no package dependency.
interface cwpa_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [11:0] kernel_index;
	logic [11:0] channel_index;
	logic [2:0]  tap_row;
	logic [2:0]  tap_col;
	logic [15:0] element_value;
	modport source(output valid, func, kernel_index, channel_index, tap_row, tap_col,
		element_value, input ready);
	modport sink(input valid, func, kernel_index, channel_index, tap_row, tap_col,
		element_value, output ready);
endinterface

interface cwpa_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] byte_offset;
	logic [1:0]  element_bytes;
	logic [15:0] placed_value;
	logic        status;
	modport source(output valid, byte_offset, element_bytes, placed_value, status,
		input ready);
	modport sink(input valid, byte_offset, element_bytes, placed_value, status,
		output ready);
endinterface

/* hdl/cwpa_cfg.sv */
// APB-style configuration register file of the packed weight address generator.
// Depends on cwpa_pkg for the register map and the configuration struct.
module cwpa_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [4:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output cwpa_pkg::cfg_t      cfg
);
	cwpa_pkg::cfg_t cfg_q;
	logic           wr;
	logic [2:0]     idx;

	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;
	assign idx    = paddr[4:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kw    <= 3'd1;
			cfg_q.kh    <= 3'd1;
			cfg_q.cc    <= 13'd1;
			cfg_q.kc    <= 13'd1;
			cfg_q.quant <= 1'b0;
			cfg_q.prelu <= 1'b0;
		end else if (wr) begin
			unique case (idx)
				cwpa_pkg::REG_KW:    cfg_q.kw    <= pwdata[2:0];
				cwpa_pkg::REG_KH:    cfg_q.kh    <= pwdata[2:0];
				cwpa_pkg::REG_CC:    cfg_q.cc    <= pwdata[12:0];
				cwpa_pkg::REG_KC:    cfg_q.kc    <= pwdata[12:0];
				cwpa_pkg::REG_QUANT: cfg_q.quant <= pwdata[0];
				cwpa_pkg::REG_PRELU: cfg_q.prelu <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			cwpa_pkg::REG_KW:    prdata = {29'd0, cfg_q.kw};
			cwpa_pkg::REG_KH:    prdata = {29'd0, cfg_q.kh};
			cwpa_pkg::REG_CC:    prdata = {19'd0, cfg_q.cc};
			cwpa_pkg::REG_KC:    prdata = {19'd0, cfg_q.kc};
			cwpa_pkg::REG_QUANT: prdata = {31'd0, cfg_q.quant};
			cwpa_pkg::REG_PRELU: prdata = {31'd0, cfg_q.prelu};
			default:             prdata = 32'd0;
		endcase
	end
endmodule

/* hdl/cwpa_decode.sv */
// First pipeline stage: decodes the configuration and the request indices into
// tile counts, group sizes, the tile slot and the range check. Depends on cwpa_pkg.
module cwpa_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  cwpa_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  cwpa_pkg::req_t      req,
	output logic                out_valid,
	input  logic                out_ready,
	output cwpa_pkg::s1_t       out_data
);
	logic          v_s1;
	cwpa_pkg::s1_t d_s1;
	cwpa_pkg::s1_t nx;

	logic [2:0]  kmax, p;
	logic        cfg_ok, p1;
	logic [12:0] nt;
	logic [18:0] ntb;
	logic [19:0] ntb_e;
	logic [9:0]  ng, ngm1;
	logic [12:0] lastw;
	logic [8:0]  g;
	logic [12:0] kdiff;
	logic [3:0]  mcount;
	logic [8:0]  cci;
	logic [12:0] rem;
	logic [6:0]  csz;
	logic [7:0]  base, trow3, rowv, colv, cell8;
	logic [3:0]  sel7;
	logic [11:0] cidx;

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_data  = d_s1;
	assign cidx      = req.channel_index;

	always_comb begin
		kmax   = (cfg.kw > cfg.kh) ? cfg.kw : cfg.kh;
		p      = kmax | 3'd1;
		p1     = (p == 3'd1);
		cfg_ok = (cfg.kw != 3'd0) && (cfg.kh != 3'd0) && (cfg.cc != 13'd0)
			&& (cfg.kc != 13'd0) && (cfg.cc <= 13'(cwpa_pkg::MaxChannels))
			&& (cfg.kc <= 13'(cwpa_pkg::MaxKernels));

		unique case (p)
			3'd7:    nt = cfg.cc;
			3'd5:    nt = 13'(({1'b0, cfg.cc} + 14'd1) >> 1);
			3'd3:    nt = 13'(({1'b0, cfg.cc} + 14'd7) >> 3);
			default: nt = 13'(({1'b0, cfg.cc} + 14'd63) >> 6);
		endcase
		// Tile size is 72 elements, so nt tiles hold nt*64 + nt*8 elements.
		ntb   = 19'({nt, 6'b0}) + 19'({nt, 3'b0});
		ntb_e = cfg.quant ? {1'b0, ntb} : {ntb, 1'b0};

		ng    = 10'(({1'b0, cfg.kc} + 14'd7) >> 3);
		ngm1  = ng - 10'd1;
		lastw = cfg.kc - {ngm1, 3'b0};

		g      = req.kernel_index[11:3];
		kdiff  = cfg.kc - {1'b0, g, 3'b0};
		mcount = (kdiff >= 13'd8) ? 4'd8 : kdiff[3:0];

		cci = p1 ? {3'b0, cidx[11:6]} : cidx[11:3];
		rem = cfg.cc - (p1 ? {1'b0, cci[5:0], 6'b0} : {1'b0, cci, 3'b0});
		if (p1)
			csz = (rem >= 13'd64) ? 7'd64 : rem[6:0];
		else
			csz = (rem >= 13'd8) ? 7'd8 : rem[6:0];

		nx          = '0;
		nx.func     = req.func;
		nx.quant    = cfg.quant;
		nx.prelu    = cfg.prelu;
		nx.gsel     = (req.func == cwpa_pkg::FUNC_SIZE) ? ngm1 : {1'b0, g};
		nx.grp_full = (cfg.prelu ? 23'd32 : 23'd16) + {ntb_e, 3'b0};
		nx.cci      = cci;
		nx.mk       = req.kernel_index[2:0];
		nx.last     = lastw[3:0];
		nx.nt       = nt;
		nx.value    = req.element_value;

		unique case (p)
			3'd7: begin
				nx.mct     = 7'({mcount, 3'b0});
				nx.tiles_m = csz[3:0];
				nx.xoff    = cidx[2:0];
			end
			3'd5: begin
				nx.mct     = 7'({mcount, 2'b0});
				nx.tiles_m = 4'((csz + 7'd1) >> 1);
				nx.xoff    = {1'b0, cidx[2:1]};
			end
			default: begin
				nx.mct     = 7'(mcount);
				nx.tiles_m = 4'd1;
				nx.xoff    = 3'd0;
			end
		endcase

		// Tile rows are bottom aligned: a kernel shorter than the class starts lower.
		base  = 8'd12 + 8'(req.tap_row) - 8'(cfg.kh);
		trow3 = 8'({cidx[2:1], 1'b0}) + 8'(cidx[2:1]);
		sel7  = 4'(req.tap_row) + 4'd7 - 4'(cfg.kh);
		unique case (p)
			3'd7: begin
				rowv = base;
				colv = 8'(req.tap_col);
			end
			3'd5: begin
				rowv = base - (cidx[0] ? 8'd6 : 8'd0);
				colv = 8'(req.tap_col);
			end
			3'd3: begin
				rowv = base - trow3;
				colv = (cidx[0] ? 8'd3 : 8'd0) + 8'(req.tap_col);
			end
			default: begin
				rowv = 8'd11 - trow3 - 8'(cwpa_pkg::div3(cidx[5:3]));
				colv = (cidx[0] ? 8'd3 : 8'd0) + 8'(cwpa_pkg::mod3(cidx[5:3]));
			end
		endcase
		cell8 = {rowv[5:0], 2'b0} + {rowv[6:0], 1'b0} + colv;
		if (p == 3'd7 && req.tap_col == 3'd6)
			nx.slot = cwpa_pkg::col_seven(sel7[2:0]);
		else
			nx.slot = cell8[6:0];

		nx.err = !cfg_ok
			|| ((req.func != cwpa_pkg::FUNC_SIZE) && ({1'b0, req.kernel_index} >= cfg.kc))
			|| ((req.func == cwpa_pkg::FUNC_PRELU) && !cfg.prelu)
			|| ((req.func == cwpa_pkg::FUNC_WEIGHT) && (({1'b0, cidx} >= cfg.cc)
				|| (req.tap_row >= cfg.kh) || (req.tap_col >= cfg.kw)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_ready)
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			d_s1 <= nx;
	end
endmodule

/* hdl/cwpa_mul.sv */
// Second pipeline stage: group base product and tile index products.
// Depends on cwpa_pkg for the stage structs and function codes.
module cwpa_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cwpa_pkg::s1_t       in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output cwpa_pkg::s2_t       out_data
);
	logic          v_s2;
	cwpa_pkg::s2_t d_s2;
	cwpa_pkg::s2_t nx;
	logic [32:0]   gprod;

	assign in_ready  = !v_s2 || out_ready;
	assign out_valid = v_s2;
	assign out_data  = d_s2;

	always_comb begin
		gprod    = 33'(in_data.gsel) * 33'(in_data.grp_full);
		nx       = '0;
		nx.func  = in_data.func;
		nx.err   = in_data.err;
		nx.quant = in_data.quant;
		nx.prelu = in_data.prelu;
		nx.gmul  = gprod[31:0];
		nx.slot  = in_data.slot;
		nx.mk    = in_data.mk;
		nx.value = in_data.value;
		// For the size query the tile index slot carries the tiles of the last group.
		if (in_data.func == cwpa_pkg::FUNC_SIZE)
			nx.tindex = 17'(in_data.last) * 17'(in_data.nt);
		else
			nx.tindex = 17'(in_data.mct) * 17'(in_data.cci)
				+ 17'(in_data.mk) * 17'(in_data.tiles_m) + 17'(in_data.xoff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (in_ready)
			v_s2 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid)
			d_s2 <= nx;
	end
endmodule

/* hdl/cwpa_sum.sv */
// Third and fourth pipeline stages: partial sums, then the final add, padding,
// saturation and the output register. Depends on cwpa_pkg.
module cwpa_sum (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  cwpa_pkg::s2_t       in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         byte_offset,
	output logic [1:0]          element_bytes,
	output logic [15:0]         placed_value,
	output logic                status
);
	logic          v_s3, v_s4, rdy_s3, rdy_s4;
	cwpa_pkg::s3_t d_s3, nx;
	logic [24:0]   tb;
	logic [25:0]   bias_b;
	logic [33:0]   total;
	logic [31:0]   offs;
	logic [31:0]   off_s4;
	logic [1:0]    eb_s4;
	logic [15:0]   pv_s4;
	logic          st_s4;

	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign in_ready = rdy_s3;

	always_comb begin
		tb = 25'({in_data.tindex, 6'b0}) + 25'({in_data.tindex, 3'b0});
		if (!in_data.quant)
			tb = {tb[23:0], 1'b0};
		bias_b   = in_data.prelu ? 26'd32 : 26'd16;
		nx       = '0;
		nx.func  = in_data.func;
		nx.err   = in_data.err;
		nx.suma  = (in_data.quant ? 33'(cwpa_pkg::HeadBytes) : 33'd0) + 33'(in_data.gmul);
		nx.value = in_data.value;
		unique case (in_data.func)
			cwpa_pkg::FUNC_WEIGHT: begin
				nx.sumb   = bias_b + 26'(tb)
					+ (in_data.quant ? 26'(in_data.slot) : 26'({in_data.slot, 1'b0}));
				nx.ebytes = in_data.quant ? 2'd1 : 2'd2;
				if (in_data.quant)
					nx.value = {8'd0, in_data.value[7:0]};
			end
			cwpa_pkg::FUNC_BIAS: begin
				nx.sumb   = 26'({in_data.mk, 1'b0});
				nx.ebytes = 2'd2;
			end
			cwpa_pkg::FUNC_PRELU: begin
				nx.sumb   = 26'(cwpa_pkg::BiasBytes) + 26'({in_data.mk, 1'b0});
				nx.ebytes = 2'd2;
			end
			default: begin
				// Size query: the +15 rounds the total up to a 16-byte multiple.
				nx.sumb   = bias_b + 26'(tb) + 26'd15;
				nx.ebytes = 2'd0;
				nx.value  = 16'd0;
			end
		endcase
	end

	always_comb begin
		total = 34'(d_s3.suma) + 34'(d_s3.sumb);
		if (d_s3.func == cwpa_pkg::FUNC_SIZE)
			total[3:0] = 4'd0;
		offs = (total[33:32] != 2'd0) ? 32'hFFFF_FFFF : total[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s3)
				v_s3 <= in_valid;
			if (rdy_s4)
				v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && in_valid)
			d_s3 <= nx;
		if (rdy_s4 && v_s3) begin
			off_s4 <= d_s3.err ? 32'd0 : offs;
			eb_s4  <= d_s3.err ? 2'd0 : d_s3.ebytes;
			pv_s4  <= d_s3.err ? 16'd0 : d_s3.value;
			st_s4  <= d_s3.err;
		end
	end

	assign out_valid     = v_s4;
	assign byte_offset   = off_s4;
	assign element_bytes = eb_s4;
	assign placed_value  = pv_s4;
	assign status        = st_s4;
endmodule

/* hdl/conv_weight_pack_address.sv */
// Packed convolution weight address generator, top level.
// Uses cwpa_pkg, the channel interfaces and the cwpa_cfg/decode/mul/sum modules.
//
// Usage: each request transaction on req names one weight, bias or PReLU
// element (func 0, 1, 2) or asks for the padded total size of the packed
// buffer (func 3). Each request yields exactly one response transaction on
// rsp with the byte offset, the element byte count, the value to write and
// an error status; error responses carry zeros in the other fields.
// The layout follows the registers written through the APB-style port:
// kernel width and height, channel and kernel counts, quantized and PReLU.
// The user must write registers only while no request is in flight; the block itself does not enforce it.
// Throughput is one transaction per cycle while rsp is not stalled; each
// request passes through the four-stage pipeline (decode, multiply,
// partial sums, output register) before its response is valid.
// Stages hold their contents while the receiver stalls; ready drops only
// when every stage up to the input is full. Reset empties the pipeline and
// loads the register defaults: 1x1 kernel, one channel, one kernel, half floats.
module conv_weight_pack_address (
	input  logic         clk,
	input  logic         arst_n,
	cwpa_req_if.sink     req,
	cwpa_rsp_if.source   rsp,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);
	cwpa_pkg::cfg_t cfg;
	cwpa_pkg::req_t req_d;
	cwpa_pkg::s1_t  d1;
	cwpa_pkg::s2_t  d2;
	logic           v1, r1, v2, r2;

	assign req_d.func          = req.func;
	assign req_d.kernel_index  = req.kernel_index;
	assign req_d.channel_index = req.channel_index;
	assign req_d.tap_row       = req.tap_row;
	assign req_d.tap_col       = req.tap_col;
	assign req_d.element_value = req.element_value;

	cwpa_cfg u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	cwpa_decode u_decode (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_valid(req.valid), .in_ready(req.ready),
		.req(req_d), .out_valid(v1), .out_ready(r1), .out_data(d1)
	);

	cwpa_mul u_mul (
		.clk(clk), .arst_n(arst_n), .in_valid(v1), .in_ready(r1), .in_data(d1),
		.out_valid(v2), .out_ready(r2), .out_data(d2)
	);

	cwpa_sum u_sum (
		.clk(clk), .arst_n(arst_n), .in_valid(v2), .in_ready(r2), .in_data(d2),
		.out_valid(rsp.valid), .out_ready(rsp.ready), .byte_offset(rsp.byte_offset),
		.element_bytes(rsp.element_bytes), .placed_value(rsp.placed_value),
		.status(rsp.status)
	);
endmodule

/* hdl/cwpa_checker.sv */
// Port-level checker for the packed weight address generator, bound to the top level.
// Depends only on the top level's ports.
module cwpa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] byte_offset,
	input logic [1:0]  element_bytes,
	input logic [15:0] placed_value,
	input logic        status
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> byte_offset == 32'd0 && element_bytes == 2'd0
			&& placed_value == 16'd0)
		else $error("error response carries nonzero fields");

	a_byte_val: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && element_bytes == 2'd1 |-> placed_value[15:8] == 8'd0)
		else $error("one-byte element with high byte set");

	a_size_pad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status && element_bytes == 2'd0 |->
			byte_offset[3:0] == 4'd0 && placed_value == 16'd0)
		else $error("size response not padded to 16 bytes");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled while output is empty");
endmodule

bind conv_weight_pack_address cwpa_checker u_cwpa_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(req.ready),
	.out_valid(rsp.valid), .out_ready(rsp.ready), .byte_offset(rsp.byte_offset),
	.element_bytes(rsp.element_bytes), .placed_value(rsp.placed_value),
	.status(rsp.status)
);
